/* rtl/core/pdd_pkg.sv */
// ----------------------------------------------------------------------------
// PI distance drive package
// Shared types and constants for the distance drive controller.
// ----------------------------------------------------------------------------
package pdd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned MAC_A_W = 33;
  localparam int unsigned MAC_B_W = 17;
  localparam int unsigned MAC_P_W = MAC_A_W + MAC_B_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_MM     = 3'd0,
    CFG_PROP_GAIN     = 3'd1,
    CFG_INTEGRAL_GAIN = 3'd2,
    CFG_MM_PER_COUNT  = 3'd3,
    CFG_EFFORT_CLAMP  = 3'd4,
    CFG_WINDUP_LIMIT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] target_mm;
    logic [15:0]        prop_gain;
    logic [15:0]        integral_gain;
    logic [23:0]        mm_per_count;
    logic [6:0]         effort_clamp;
    logic [7:0]         windup_limit;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic accum;
    logic shift;
  } mac_op_t;

  localparam logic [15:0] TARGET_RESET   = 16'd0;
  localparam logic [15:0] PGAIN_RESET    = 16'd205;
  localparam logic [15:0] IGAIN_RESET    = 16'd26;
  localparam logic [23:0] SCALE_RESET    = 24'd23563;
  localparam logic [6:0]  CLAMP_RESET    = 7'd60;
  localparam logic [7:0]  WINDUP_RESET   = 8'd100;
  localparam logic [6:0]  CLAMP_MAX      = 7'd100;
  localparam int unsigned DONE_MARGIN_MM = 5;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned SCALE_SPLIT    = 12;

endpackage

/* rtl/core/pi_distance_drive_controller.sv */
// ----------------------------------------------------------------------------
// PI distance drive controller
// One control tick in, one pair of wheel drive commands out.
// ----------------------------------------------------------------------------
// Each accepted tick steps the sequencer through POS_LO, POS_HI, ERR, PROP,
// INTEG, EFF and OUT; OUT waits while out_stall_i holds the last result, and
// a tick with the move already done skips PROP, INTEG and EFF. The steps serve
// the single shared multiplier, used twice for the position scale and once
// each for the proportional and the integral term. in_stall_o stays high while
// a tick is in work; a finished result may wait in the output register while
// the next tick is accepted. Config writes are always taken (cfg_ready_o is 1).
module pi_distance_drive_controller #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pdd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pdd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           start_move_i,
  input  logic signed [COUNT_WIDTH-1:0]  left_count_i,
  input  logic signed [COUNT_WIDTH-1:0]  right_count_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [15:0]             left_drive_o,
  output logic signed [15:0]             right_drive_o,
  output logic [14:0]                    position_mm_o,
  output logic                           move_done_o
);
  import pdd_pkg::*;

  localparam int unsigned W     = COUNT_WIDTH;
  localparam int unsigned PW    = W + 24;
  localparam int unsigned ACC_W = (PW + 2 > 51) ? PW + 2 : 51;
  localparam int unsigned DW    = (PW + 2 > 49) ? PW + 2 : 49;
  localparam int unsigned QW    = DW - FRAC_BITS;
  localparam int unsigned SW    = W + 6;
  localparam int unsigned IW    = PW - FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_POS_LO, ST_POS_HI, ST_ERR, ST_PROP, ST_INTEG, ST_EFF, ST_OUT
  } state_e;

  cfg_t cfg;

  state_e state_q;
  logic signed [W-1:0]  left_q, right_q;
  logic [W-1:0]         avg_q;
  logic [PW-1:0]        pos_q;
  logic signed [31:0]   err_q, esum_q;
  logic signed [7:0]    last_eff_q, eff_q;
  logic                 done_q, hit_q;
  logic                 out_valid_q;
  logic signed [15:0]   left_drive_q, right_drive_q;
  logic [14:0]          position_q;
  logic                 move_done_q;

  mac_op_t                   mac_op;
  logic signed [MAC_A_W-1:0] mac_a;
  logic signed [MAC_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   acc;

  pdd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pdd_mac #(.ACC_W(ACC_W)) u_mac (
    .clk_i(clk_i),
    .op_i (mac_op),
    .a_i  (mac_a),
    .b_i  (mac_b),
    .acc_o(acc)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);

  // Input stage: half of the absolute count sum
  logic signed [W:0] sum_in;
  logic [W:0]        abs_in;
  always_comb begin
    sum_in = {left_count_i[W-1], left_count_i} + {right_count_i[W-1], right_count_i};
    abs_in = sum_in[W] ? (W+1)'(0) - sum_in : sum_in;
  end

  always_comb begin
    mac_op = '0;
    mac_a  = '0;
    mac_b  = '0;
    unique case (state_q)
      ST_POS_LO: begin
        mac_op = '{en: 1'b1, accum: 1'b0, shift: 1'b0};
        mac_a  = MAC_A_W'({1'b0, avg_q});
        mac_b  = MAC_B_W'(cfg.mm_per_count[SCALE_SPLIT-1:0]);
      end
      ST_POS_HI: begin
        mac_op = '{en: 1'b1, accum: 1'b1, shift: 1'b1};
        mac_a  = MAC_A_W'({1'b0, avg_q});
        mac_b  = MAC_B_W'(cfg.mm_per_count[23:SCALE_SPLIT]);
      end
      ST_PROP: begin
        mac_op = '{en: 1'b1, accum: 1'b0, shift: 1'b0};
        mac_a  = {err_q[31], err_q};
        mac_b  = {1'b0, cfg.prop_gain};
      end
      ST_INTEG: begin
        mac_op = '{en: 1'b1, accum: 1'b1, shift: 1'b0};
        mac_a  = {esum_q[31], esum_q};
        mac_b  = {1'b0, cfg.integral_gain};
      end
      default: ;
    endcase
  end

  // Position error, truncated toward zero and saturated to 32 bits
  logic [PW-1:0]        pos_now;
  logic signed [DW-1:0] diff, rnd;
  logic signed [QW-1:0] quo;
  logic [QW-32:0]       quo_hi;
  logic signed [31:0]   err_now;
  logic [16:0]          tmag;
  logic                 hit_now;
  always_comb begin
    pos_now = acc[PW-1:0];
    diff    = {{(DW-32){cfg.target_mm[15]}}, cfg.target_mm, 16'd0}
              - $signed({{(DW-PW){1'b0}}, pos_now});
    rnd     = diff + $signed({{(DW-FRAC_BITS){1'b0}}, {FRAC_BITS{diff[DW-1]}}});
    quo     = rnd[DW-1:FRAC_BITS];
    quo_hi  = quo[QW-1:31];
    if (quo_hi == '0 || quo_hi == '1) begin
      err_now = quo[31:0];
    end else begin
      err_now = quo[QW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    tmag    = cfg.target_mm[15] ? 17'd0 - {1'b1, cfg.target_mm}
                                : {1'b0, cfg.target_mm};
    hit_now = ({1'b0, pos_now} + (PW+1)'(DONE_MARGIN_MM << FRAC_BITS))
              > (PW+1)'({tmag, 16'd0});
  end

  // Saturating integral update under the windup limit
  logic [7:0]         eff_mag;
  logic signed [32:0] esum_sum;
  logic signed [31:0] esum_next;
  always_comb begin
    eff_mag  = last_eff_q[7] ? 8'd0 - last_eff_q : last_eff_q;
    esum_sum = {esum_q[31], esum_q} + {err_q[31], err_q};
    if (esum_sum[32] != esum_sum[31]) begin
      esum_next = esum_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      esum_next = esum_sum[31:0];
    end
  end

  // Effort clamp and truncation to percent
  logic [6:0]              clamp_eff;
  logic signed [ACC_W-1:0] lim;
  logic signed [15:0]      u_sat, u_rnd;
  logic signed [7:0]       eff_now;
  always_comb begin
    clamp_eff = (cfg.effort_clamp > CLAMP_MAX) ? CLAMP_MAX : cfg.effort_clamp;
    lim       = $signed(ACC_W'({clamp_eff, 8'd0}));
    priority if (acc > lim) begin
      u_sat = lim[15:0];
    end else if (acc < -lim) begin
      u_sat = 16'sd0 - lim[15:0];
    end else begin
      u_sat = acc[15:0];
    end
    u_rnd   = u_sat + $signed({8'd0, {8{u_sat[15]}}});
    eff_now = u_rnd[15:8];
  end

  // Drive commands with straightness correction
  logic signed [15:0]   pwr;
  logic signed [W:0]    cdiff;
  logic signed [SW-1:0] corr, pwr_ext, ld_raw, rd_raw;
  logic signed [15:0]   ld_sat, rd_sat;
  logic [IW-1:0]        pos_int;
  logic [14:0]          pos_mm;
  always_comb begin
    pwr     = ({{8{eff_q[7]}}, eff_q} <<< 5) + ({{8{eff_q[7]}}, eff_q} <<< 4)
              + ({{8{eff_q[7]}}, eff_q} <<< 1);
    cdiff   = {left_q[W-1], left_q} - {right_q[W-1], right_q};
    corr    = ({{5{cdiff[W]}}, cdiff} <<< 3) + ({{5{cdiff[W]}}, cdiff} <<< 1);
    pwr_ext = {{(SW-16){pwr[15]}}, pwr};
    ld_raw  = pwr_ext - corr;
    rd_raw  = pwr_ext + corr;
    if (ld_raw[SW-1:15] == '0 || ld_raw[SW-1:15] == '1) begin
      ld_sat = ld_raw[15:0];
    end else begin
      ld_sat = ld_raw[SW-1] ? 16'sh8000 : 16'sh7FFF;
    end
    if (rd_raw[SW-1:15] == '0 || rd_raw[SW-1:15] == '1) begin
      rd_sat = rd_raw[15:0];
    end else begin
      rd_sat = rd_raw[SW-1] ? 16'sh8000 : 16'sh7FFF;
    end
    pos_int = pos_q[PW-1:FRAC_BITS];
    pos_mm  = (pos_int[IW-1:15] != '0) ? 15'h7FFF : pos_int[14:0];
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      left_q        <= '0;
      right_q       <= '0;
      avg_q         <= '0;
      pos_q         <= '0;
      err_q         <= '0;
      esum_q        <= '0;
      last_eff_q    <= '0;
      eff_q         <= '0;
      done_q        <= 1'b0;
      hit_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      left_drive_q  <= '0;
      right_drive_q <= '0;
      position_q    <= '0;
      move_done_q   <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            left_q  <= left_count_i;
            right_q <= right_count_i;
            avg_q   <= abs_in[W:1];
            if (start_move_i) begin
              esum_q     <= '0;
              last_eff_q <= '0;
              done_q     <= 1'b0;
            end
            state_q <= ST_POS_LO;
          end
        end
        ST_POS_LO: state_q <= ST_POS_HI;
        ST_POS_HI: state_q <= ST_ERR;
        ST_ERR: begin
          pos_q   <= pos_now;
          err_q   <= err_now;
          hit_q   <= hit_now;
          state_q <= done_q ? ST_OUT : ST_PROP;
        end
        ST_PROP: begin
          if (eff_mag <= cfg.windup_limit) begin
            esum_q <= esum_next;
          end
          state_q <= ST_INTEG;
        end
        ST_INTEG: state_q <= ST_EFF;
        ST_EFF: begin
          eff_q      <= eff_now;
          last_eff_q <= eff_now;
          if (hit_q) begin
            done_q <= 1'b1;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            left_drive_q  <= done_q ? 16'sd0 : ld_sat;
            right_drive_q <= done_q ? 16'sd0 : rd_sat;
            position_q    <= pos_mm;
            move_done_q   <= done_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = left_drive_q;
  assign right_drive_o = right_drive_q;
  assign position_mm_o = position_q;
  assign move_done_o   = move_done_q;

endmodule

/* rtl/core/pdd_cfg.sv */
// ----------------------------------------------------------------------------
// PI distance drive configuration registers
// Holds gains, scale, clamp, windup limit and target written over the port.
// ----------------------------------------------------------------------------
module pdd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pdd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output pdd_pkg::cfg_t                  cfg_o
);
  import pdd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_mm     <= TARGET_RESET;
      cfg_q.prop_gain     <= PGAIN_RESET;
      cfg_q.integral_gain <= IGAIN_RESET;
      cfg_q.mm_per_count  <= SCALE_RESET;
      cfg_q.effort_clamp  <= CLAMP_RESET;
      cfg_q.windup_limit  <= WINDUP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TARGET_MM:     cfg_q.target_mm     <= cfg_data_i[15:0];
        CFG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_data_i[15:0];
        CFG_INTEGRAL_GAIN: cfg_q.integral_gain <= cfg_data_i[15:0];
        CFG_MM_PER_COUNT:  cfg_q.mm_per_count  <= cfg_data_i[23:0];
        CFG_EFFORT_CLAMP:  cfg_q.effort_clamp  <= cfg_data_i[6:0];
        CFG_WINDUP_LIMIT:  cfg_q.windup_limit  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/pdd_mac.sv */
// ----------------------------------------------------------------------------
// PI distance drive shared multiply-accumulate unit
// One signed multiplier with an optional shift and a wide accumulator.
// ----------------------------------------------------------------------------
module pdd_mac #(
  parameter int unsigned ACC_W = 51
) (
  input  logic                                clk_i,
  input  pdd_pkg::mac_op_t                    op_i,
  input  logic signed [pdd_pkg::MAC_A_W-1:0]  a_i,
  input  logic signed [pdd_pkg::MAC_B_W-1:0]  b_i,
  output logic signed [ACC_W-1:0]             acc_o
);
  import pdd_pkg::*;

  logic signed [MAC_P_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   addend;
  logic signed [ACC_W-1:0]   acc_d;
  logic signed [ACC_W-1:0]   acc_q;

  always_comb begin
    prod     = a_i * b_i;
    prod_ext = {{(ACC_W-MAC_P_W){prod[MAC_P_W-1]}}, prod};
    addend   = op_i.shift ? (prod_ext <<< SCALE_SPLIT) : prod_ext;
    acc_d    = (op_i.accum ? acc_q : '0) + addend;
  end

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI distance drive controller testbench
// Drives control ticks through the block under random valid/stall pressure,
// predicts each drive result with a local PI model of the controller state,
// and checks every result field in order across several register settings.
// ----------------------------------------------------------------------------
module tb;
  import pdd_pkg::*;

  localparam int unsigned COUNT_W     = 24;
  localparam longint      COUNT_MAX   = 8388607;
  localparam longint      COUNT_MIN   = -8388608;
  localparam longint      ACC_MAX     = 64'sd2147483647;
  localparam longint      ACC_MIN     = -64'sd2147483648;
  localparam longint      DRIVE_MAX   = 32767;
  localparam longint      DRIVE_MIN   = -32768;
  localparam longint      Q16_ONE     = 65536;
  localparam int          CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                      start_move;
    logic signed [COUNT_W-1:0] left_count;
    logic signed [COUNT_W-1:0] right_count;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic [14:0]        position_mm;
    logic               move_done;
  } drive_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      start_move = 1'b0;
  logic signed [COUNT_W-1:0] left_count = '0;
  logic signed [COUNT_W-1:0] right_count = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [15:0]        left_drive;
  logic signed [15:0]        right_drive;
  logic [14:0]               position_mm;
  logic                      move_done;

  tick_t         pending_ticks[$];
  drive_result_t expected_drives[$];

  int send_idle_pct  = 32;
  int recv_stall_pct = 54;
  int mismatch_count = 0;
  int result_count   = 0;
  int cycle_count    = 0;

  logic signed [15:0] set_target = TARGET_RESET;
  logic [15:0]        set_pgain  = PGAIN_RESET;
  logic [15:0]        set_igain  = IGAIN_RESET;
  logic [23:0]        set_scale  = SCALE_RESET;
  logic [6:0]         set_clamp  = CLAMP_RESET;
  logic [7:0]         set_windup = WINDUP_RESET;

  longint acc_error    = 0;
  longint held_effort  = 0;
  bit     move_latched = 1'b0;

  pi_distance_drive_controller #(
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .start_move_i (start_move),
    .left_count_i (left_count),
    .right_count_i(right_count),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .left_drive_o (left_drive),
    .right_drive_o(right_drive),
    .position_mm_o(position_mm),
    .move_done_o  (move_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic drive_result_t predict_drive(tick_t t);
    longint lc, rc, sum, avg, pos_q16, pos_int, err, u, lim, eff, ld, rd, tmag, mag;
    drive_result_t r;
    lc = t.left_count;
    rc = t.right_count;
    if (t.start_move) begin
      acc_error    = 0;
      held_effort  = 0;
      move_latched = 1'b0;
    end
    sum     = lc + rc;
    avg     = (sum < 0 ? -sum : sum) >> 1;
    pos_q16 = avg * longint'(set_scale);
    pos_int = pos_q16 >> 16;
    ld = 0;
    rd = 0;
    if (!move_latched) begin
      err = clip((longint'(set_target) * Q16_ONE - pos_q16) / Q16_ONE, ACC_MIN, ACC_MAX);
      mag = (held_effort < 0) ? -held_effort : held_effort;
      if (mag <= longint'(set_windup))
        acc_error = clip(acc_error + err, ACC_MIN, ACC_MAX);
      u   = longint'(set_pgain) * err + longint'(set_igain) * acc_error;
      lim = 256 * longint'((set_clamp > CLAMP_MAX) ? CLAMP_MAX : set_clamp);
      eff = clip(u, -lim, lim) / 256;
      held_effort = eff;
      ld = clip(eff * 50 - (lc - rc) * 10, DRIVE_MIN, DRIVE_MAX);
      rd = clip(eff * 50 + (lc - rc) * 10, DRIVE_MIN, DRIVE_MAX);
      tmag = (set_target < 0) ? -longint'(set_target) : longint'(set_target);
      if (pos_q16 + DONE_MARGIN_MM * Q16_ONE > tmag * Q16_ONE)
        move_latched = 1'b1;
    end
    if (move_latched) begin
      ld = 0;
      rd = 0;
    end
    r.left_drive  = ld[15:0];
    r.right_drive = rd[15:0];
    r.position_mm = (pos_int > DRIVE_MAX) ? 15'h7fff : pos_int[14:0];
    r.move_done   = move_latched;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("MISMATCH result %0d: %s", result_count, msg);
  endtask

  always @(posedge clk or negedge rst_n) begin : driver_p
    tick_t cur;
    tick_t nxt;
    logic  taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && (in_stall === 1'b0);
      if (taken) begin
        cur.start_move  = start_move;
        cur.left_count  = left_count;
        cur.right_count = right_count;
        expected_drives.push_back(predict_drive(cur));
      end
      if (!in_valid || taken) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_ticks.pop_front();
          in_valid    <= 1'b1;
          start_move  <= nxt.start_move;
          left_count  <= nxt.left_count;
          right_count <= nxt.right_count;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : monitor_p
    drive_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_drives.size() == 0) begin
          report_mismatch("result with no tick pending");
        end else begin
          want = expected_drives.pop_front();
          if (left_drive !== want.left_drive)
            report_mismatch($sformatf("left_drive got %0d want %0d", left_drive,
                                      want.left_drive));
          if (right_drive !== want.right_drive)
            report_mismatch($sformatf("right_drive got %0d want %0d", right_drive,
                                      want.right_drive));
          if (position_mm !== want.position_mm)
            report_mismatch($sformatf("position_mm got %0d want %0d", position_mm,
                                      want.position_mm));
          if (move_done !== want.move_done)
            report_mismatch($sformatf("move_done got %b want %b", move_done,
                                      want.move_done));
        end
        result_count++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_tick(bit s, longint l, longint r);
    tick_t t;
    t.start_move  = s;
    t.left_count  = l[COUNT_W-1:0];
    t.right_count = r[COUNT_W-1:0];
    pending_ticks.push_back(t);
  endtask

  // ramp both wheels toward the target, run a few ticks past the finish
  task automatic push_move();
    longint tmag, need, step, base;
    int     n, sgn;
    bit     clean;
    clean = ($urandom_range(9) != 0);
    n     = $urandom_range(3, 12);
    sgn   = $urandom_range(1) ? 1 : -1;
    tmag  = (set_target < 0) ? -longint'(set_target) : longint'(set_target);
    if (set_scale == 0)
      need = $urandom_range(2000);
    else
      need = ((tmag + DONE_MARGIN_MM) * Q16_ONE) / longint'(set_scale) + 1;
    if (need > 4000000)
      need = 4000000;
    step = need / n + 1;
    for (int k = 0; k < n + 3; k++) begin
      base = sgn * step * k;
      push_tick((k == 0) && clean, base + $urandom_range(60) - 30,
                base + $urandom_range(60) - 30);
    end
  endtask

  task automatic push_noise();
    tick_t t;
    t.start_move = ($urandom_range(3) == 0);
    t.left_count = COUNT_W'($urandom());
    if ($urandom_range(1))
      t.right_count = COUNT_W'($urandom());
    else
      t.right_count = COUNT_W'($urandom_range(6) - 3 - t.left_count);
    pending_ticks.push_back(t);
  endtask

  function automatic longint pick(longint lo, longint hi, longint typ_lo, longint typ_hi);
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      default: return typ_lo + longint'($urandom_range(32'(typ_hi - typ_lo)));
    endcase
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_drives.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_settings(logic signed [15:0] tgt, logic [15:0] pg, logic [15:0] ig,
                                logic [23:0] mpc, logic [6:0] cl, logic [7:0] wl);
    logic [CFG_DATA_W-1:0] word;
    cfg_idx_e              idx;
    for (int i = CFG_TARGET_MM; i <= CFG_WINDUP_LIMIT; i++) begin
      idx  = cfg_idx_e'(i);
      word = CFG_DATA_W'($urandom());
      case (idx)
        CFG_TARGET_MM:     word[15:0] = tgt;
        CFG_PROP_GAIN:     word[15:0] = pg;
        CFG_INTEGRAL_GAIN: word[15:0] = ig;
        CFG_MM_PER_COUNT:  word       = mpc;
        CFG_EFFORT_CLAMP:  word[6:0]  = cl;
        default:           word[7:0]  = wl;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= word;
      do @(posedge clk);
      while (cfg_ready !== 1'b1);
      case (idx)
        CFG_TARGET_MM:     set_target = tgt;
        CFG_PROP_GAIN:     set_pgain  = pg;
        CFG_INTEGRAL_GAIN: set_igain  = ig;
        CFG_MM_PER_COUNT:  set_scale  = mpc;
        CFG_EFFORT_CLAMP:  set_clamp  = cl;
        default:           set_windup = wl;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int base_n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_tick(1, 0, 0);
    push_tick(0, 100, -100);
    wait_idle();
    write_settings(1000, PGAIN_RESET, IGAIN_RESET, SCALE_RESET, CLAMP_RESET, WINDUP_RESET);
    push_tick(1, 0, 0);
    push_tick(0, COUNT_MAX, COUNT_MIN);
    push_tick(0, COUNT_MIN, COUNT_MAX);
    push_tick(0, 1000, 1000);
    push_tick(0, 2000, 2010);
    push_tick(0, 2700, 2700);
    push_tick(0, 2800, 2800);
    push_tick(0, 0, 0);
    push_tick(1, COUNT_MAX, COUNT_MAX);
    push_tick(1, COUNT_MIN, COUNT_MIN);
    push_tick(1, -1, -2);
    wait_idle();
    write_settings(-32768, 16'hffff, 16'hffff, 24'hffffff, 7'd127, 8'd0);
    push_tick(1, 1, 1);
    push_tick(0, 2, 2);
    push_tick(0, COUNT_MIN, COUNT_MIN);
    wait_idle();
    write_settings(32767, 16'd0, 16'd0, 24'd0, 7'd0, 8'd255);
    push_tick(1, 5, -5);
    push_tick(0, COUNT_MAX, COUNT_MIN);
    push_tick(0, -3, 3);

    for (int s = 0; s < 8; s++) begin
      wait_idle();
      send_idle_pct  = (s < 3) ? 32 : ((s < 6) ? 54 : 0);
      recv_stall_pct = (s < 3) ? 54 : ((s < 6) ? 32 : 0);
      write_settings(16'(pick(-32768, 32767, -3000, 3000)), 16'(pick(0, 65535, 20, 800)),
                     16'(pick(0, 65535, 0, 200)), 24'(pick(0, 16777215, 8000, 80000)),
                     7'(pick(0, 127, 1, 110)), 8'(pick(0, 255, 0, 150)));
      base_n = pending_ticks.size();
      while (pending_ticks.size() - base_n < 100) begin
        if ($urandom_range(4) != 0)
          push_move();
        else
          repeat ($urandom_range(1, 4)) push_noise();
      end
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
